@@ hdl/isp_pkg.sv @@
// ---------------------------------------------------------------------------
// isp_pkg
// shared types, codes and helpers for the integer string parser
// ---------------------------------------------------------------------------
package isp_pkg;

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_SIGNED = 2'd1;
    localparam logic [1:0] PH_ZERO   = 2'd2;
    localparam logic [1:0] PH_DIGITS = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADCHAR  = 3'd1;
    localparam logic [2:0] ST_NODIGITS = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_BADBASE  = 3'd4;

    localparam logic [1:0] REG_NUMBER_BASE   = 2'd0;
    localparam logic [1:0] REG_TARGET_WIDTH  = 2'd1;
    localparam logic [1:0] REG_TARGET_SIGNED = 2'd2;

    localparam logic [4:0] BASE_RESET  = 5'd10;
    localparam logic [1:0] WIDTH_RESET = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_B     = 8'h62;

    localparam logic [4:0] BASE_TWO     = 5'd2;
    localparam logic [4:0] BASE_TEN     = 5'd10;
    localparam logic [4:0] BASE_SIXTEEN = 5'd16;
    localparam logic [4:0] BASE_AUTO    = 5'd0;

    typedef struct packed {
        logic [1:0]  phase;
        logic [63:0] acc;
        logic        neg;
        logic [4:0]  eb;
        logic        seen;
        logic [2:0]  status;
        logic [7:0]  bad;
    } parse_state_t;

    typedef struct packed {
        logic [4:0] number_base;
        logic [1:0] target_width;
        logic       target_signed;
    } cfg_t;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  status;
        logic [7:0]  bad_character;
    } result_t;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5a)
            return c + 8'h20;
        return c;
    endfunction

    // value of a digit character, 16 when it is no digit at all
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [7:0] lc;
        lc = lower_ascii(c);
        if (c >= 8'h30 && c <= 8'h39)
            return 5'(c - 8'h30);
        if (lc >= 8'h61 && lc <= 8'h66)
            return 5'(lc - 8'h57);
        return 5'd16;
    endfunction

endpackage

@@ hdl/isp_step.sv @@
// ---------------------------------------------------------------------------
// isp_step
// next-state and result logic for one character of the string
// ---------------------------------------------------------------------------
module isp_step
    import isp_pkg::*;
(
    input  parse_state_t state,
    input  cfg_t         cfg,
    input  logic [7:0]   character,
    output parse_state_t state_next,
    output logic         emit,
    output result_t      result
);

    logic [63:0] umax;
    logic [63:0] lim;
    logic [4:0]  base;
    logic [4:0]  digit;
    logic [68:0] prod;
    logic [69:0] sum;
    logic        do_digit;
    logic        take_first;
    logic [7:0]  lc;
    logic [2:0]  fin;
    logic [2:0]  st_cur;

    always_comb
    begin
        case (cfg.target_width)
            2'd0:    umax = 64'h0000_0000_0000_00ff;
            2'd1:    umax = 64'h0000_0000_0000_ffff;
            2'd2:    umax = 64'h0000_0000_ffff_ffff;
            default: umax = 64'hffff_ffff_ffff_ffff;
        endcase
        if (cfg.target_signed)
            lim = (umax >> 1) + {63'b0, state.neg};
        else
            lim = umax;
    end

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        result     = '0;
        do_digit   = 1'b0;
        take_first = 1'b0;
        fin        = ST_OK;
        lc         = lower_ascii(character);

        // base is sampled at the first byte of each string
        if (state.phase == PH_START && state.status == ST_OK)
        begin
            if (cfg.number_base inside {5'd1, [5'd17:5'd31]})
                state_next.status = ST_BADBASE;
            else
                state_next.eb = cfg.number_base;
        end
        st_cur = state_next.status;

        if (character == CH_NUL)
        begin
            fin = st_cur;
            if (fin == ST_OK && !state.seen)
                fin = ST_NODIGITS;
            else if (fin == ST_OK && !cfg.target_signed && state.neg)
                fin = ST_RANGE;
            else if (fin == ST_OK && state.acc > lim)
                fin = ST_RANGE;
            emit = 1'b1;
            result.status = fin;
            if (fin == ST_OK)
                result.value = state.neg ? (64'd0 - state.acc) : state.acc;
            if (fin == ST_BADCHAR)
                result.bad_character = state.bad;
            state_next        = '0;
            state_next.phase  = PH_START;
            state_next.status = ST_OK;
        end
        else if (st_cur != ST_OK)
        begin
            if (state.phase == PH_START)
                state_next.phase = PH_SIGNED;
        end
        else
        begin
            case (state.phase)
                PH_START:
                begin
                    if (character == CH_MINUS)
                    begin
                        state_next.neg   = 1'b1;
                        state_next.phase = PH_SIGNED;
                    end
                    else if (character == CH_PLUS)
                        state_next.phase = PH_SIGNED;
                    else
                        take_first = 1'b1;
                end
                PH_SIGNED:
                    take_first = 1'b1;
                PH_ZERO:
                begin
                    if (lc == CH_X && (state_next.eb == BASE_SIXTEEN
                                       || state_next.eb == BASE_AUTO))
                    begin
                        state_next.eb    = BASE_SIXTEEN;
                        state_next.seen  = 1'b0;
                        state_next.phase = PH_DIGITS;
                    end
                    else if (lc == CH_B && (state_next.eb == BASE_TWO
                                            || state_next.eb == BASE_AUTO))
                    begin
                        state_next.eb    = BASE_TWO;
                        state_next.seen  = 1'b0;
                        state_next.phase = PH_DIGITS;
                    end
                    else
                    begin
                        if (state_next.eb == BASE_AUTO)
                            state_next.eb = BASE_TEN;
                        state_next.phase = PH_DIGITS;
                        do_digit = 1'b1;
                    end
                end
                default:
                    do_digit = 1'b1;
            endcase

            if (take_first)
            begin
                if (character == CH_ZERO)
                begin
                    state_next.seen  = 1'b1;
                    state_next.phase = PH_ZERO;
                end
                else
                begin
                    if (state_next.eb == BASE_AUTO)
                        state_next.eb = BASE_TEN;
                    state_next.phase = PH_DIGITS;
                    do_digit = 1'b1;
                end
            end
        end

        base = (state_next.eb < BASE_TWO || state_next.eb > BASE_SIXTEEN)
               ? BASE_TEN : state_next.eb;
        digit = digit_of(character);
        prod  = {5'b0, state.acc} * {64'b0, base};
        sum   = {1'b0, prod} + {65'b0, digit};

        if (do_digit)
        begin
            if (digit >= base)
            begin
                state_next.status = ST_BADCHAR;
                state_next.bad    = character;
            end
            else if (sum > {6'b0, lim})
                state_next.status = ST_RANGE;
            else
            begin
                state_next.acc  = sum[63:0];
                state_next.seen = 1'b1;
            end
        end
    end

endmodule

@@ hdl/integer_string_parser_top.sv @@
// ---------------------------------------------------------------------------
// integer_string_parser_top
// parses a zero-terminated character stream into a typed integer
// ---------------------------------------------------------------------------
//  channel  | signals                            | transfer when
//  ---------+------------------------------------+-----------------------
//  input    | in_valid, in_ready, character      | in_valid & in_ready
//  result   | out_valid, out_ready, value,       | out_valid & out_ready
//           | status, bad_character              |
//  config   | cfg_write, cfg_index, cfg_data     | cfg_write
//
// one character per cycle: input register, one pass of digit logic
// (64x5 multiply, add and limit compare), result register.
// a result is registered once its terminator leaves the input register.
// input stalls only when a terminator meets a result still not taken.
// reset restores base 10, signed 64-bit target and an empty string.
// ---------------------------------------------------------------------------
module integer_string_parser_top
    import isp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  character,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] value,
    output logic [2:0]  status,
    output logic [7:0]  bad_character
);

    cfg_t         cfg_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         in_valid_reg;
    logic [7:0]   char_reg;
    logic         out_valid_reg;
    result_t      result_reg;
    result_t      result_next;
    logic         emit;
    logic         advance;

    isp_step u_step
    (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .character  (char_reg),
        .state_next (state_next),
        .emit       (emit),
        .result     (result_next)
    );

    assign advance  = in_valid_reg && !(emit && out_valid_reg && !out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.number_base   <= BASE_RESET;
            cfg_reg.target_width  <= WIDTH_RESET;
            cfg_reg.target_signed <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NUMBER_BASE:   cfg_reg.number_base   <= cfg_data;
                REG_TARGET_WIDTH:  cfg_reg.target_width  <= cfg_data[1:0];
                REG_TARGET_SIGNED: cfg_reg.target_signed <= cfg_data[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                state_reg <= state_next;
            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            char_reg <= character;
        if (advance && emit)
            result_reg <= result_next;
    end

    assign out_valid     = out_valid_reg;
    assign value         = result_reg.value;
    assign status        = result_reg.status;
    assign bad_character = result_reg.bad_character;

endmodule

@@ bench/integer_string_parser_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_string_parser_top_tb
// Drives zero-terminated character strings into the parser under several
// base and target settings, predicts every parsed result in the bench and
// compares each result transfer field by field. Starts with a short table
// of boundary and error strings, then runs random strings that are mostly
// well formed, near the range limits, with noise and corrupted bytes mixed
// in, under changing handshake pressure on both channels.
// ---------------------------------------------------------------------------
module integer_string_parser_top_tb;
    import isp_pkg::*;

    typedef struct packed {
        logic [4:0] base;
        logic [1:0] width;
        logic       sgn;
        logic       typed;
        result_t    want;
    } table_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_NUMBER_BASE;
    logic [4:0]  cfg_data = 5'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  character = CH_NUL;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] value;
    logic [2:0]  status;
    logic [7:0]  bad_character;

    // register copies
    logic [4:0]  reg_base = BASE_RESET;
    logic [1:0]  reg_width = WIDTH_RESET;
    logic        reg_signed = 1'b1;

    // parser state copy
    logic [1:0]  pr_phase = PH_START;
    logic [63:0] pr_mag = 64'd0;
    logic        pr_neg = 1'b0;
    logic [4:0]  pr_base = BASE_AUTO;
    logic        pr_seen = 1'b0;
    logic [2:0]  pr_status = ST_OK;
    logic [7:0]  pr_bad = 8'h00;

    result_t     due_numbers[$];
    result_t     last_result;
    logic [7:0]  text_buf[$];
    table_row_t  rows[$];
    string       row_text[$];

    int          tx_idle_pct = 28;
    int          rx_idle_pct = 48;
    int          fail_count = 0;
    int          chars_accepted = 0;
    int          results_seen = 0;
    int          settings_written = 0;

    integer_string_parser_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .character     (character),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .value         (value),
        .status        (status),
        .bad_character (bad_character)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [63:0] ceiling_of(input logic [1:0] w, input logic sgn,
                                               input logic minus);
        logic [63:0] umax;
        umax = (64'd1 << (8 << w)) - 64'd1;
        if (!sgn)
            return umax;
        return minus ? (umax >> 1) + 64'd1 : umax >> 1;
    endfunction

    function automatic logic [4:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 5'(c - "0");
        if (c >= "a" && c <= "f")
            return 5'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F")
            return 5'(c - "A" + 8'd10);
        return 5'd16;
    endfunction

    function automatic void reset_parse();
        pr_phase  = PH_START;
        pr_mag    = 64'd0;
        pr_neg    = 1'b0;
        pr_base   = BASE_AUTO;
        pr_seen   = 1'b0;
        pr_status = ST_OK;
        pr_bad    = 8'h00;
    endfunction

    function automatic void add_digit(input logic [7:0] c);
        logic [4:0]  b;
        logic [4:0]  d;
        logic [63:0] lim;
        b = (pr_base < BASE_TWO || pr_base > BASE_SIXTEEN) ? BASE_TEN : pr_base;
        d = digit_value(c);
        if (d >= b)
        begin
            pr_status = ST_BADCHAR;
            pr_bad    = c;
            return;
        end
        lim = ceiling_of(reg_width, reg_signed, pr_neg);
        if (pr_mag > lim / b)
        begin
            pr_status = ST_RANGE;
            return;
        end
        pr_mag = pr_mag * b;
        if (pr_mag > lim - d)
        begin
            pr_status = ST_RANGE;
            return;
        end
        pr_mag  = pr_mag + d;
        pr_seen = 1'b1;
    endfunction

    function automatic void consume_char(input logic [7:0] c);
        result_t r;
        if (pr_phase == PH_START && pr_status == ST_OK)
        begin
            if (reg_base == 5'd1 || reg_base > BASE_SIXTEEN)
                pr_status = ST_BADBASE;
            else
                pr_base = reg_base;
        end
        if (c == CH_NUL)
        begin
            r.status = pr_status;
            r.value  = 64'd0;
            if (r.status == ST_OK && !pr_seen)
                r.status = ST_NODIGITS;
            else if (r.status == ST_OK && !reg_signed && pr_neg)
                r.status = ST_RANGE;
            else if (r.status == ST_OK && pr_mag > ceiling_of(reg_width, reg_signed, pr_neg))
                r.status = ST_RANGE;
            if (r.status == ST_OK)
                r.value = pr_neg ? 64'd0 - pr_mag : pr_mag;
            r.bad_character = (r.status == ST_BADCHAR) ? pr_bad : 8'h00;
            due_numbers.push_back(r);
            reset_parse();
            return;
        end
        // bytes after the first error only move the phase on
        if (pr_status != ST_OK)
        begin
            if (pr_phase == PH_START)
                pr_phase = PH_SIGNED;
            return;
        end
        if (pr_phase == PH_START && (c == CH_MINUS || c == CH_PLUS))
        begin
            pr_neg   = (c == CH_MINUS);
            pr_phase = PH_SIGNED;
            return;
        end
        if (pr_phase == PH_START || pr_phase == PH_SIGNED)
        begin
            if (c == CH_ZERO)
            begin
                pr_seen  = 1'b1;
                pr_phase = PH_ZERO;
                return;
            end
        end
        else if (pr_phase == PH_ZERO)
        begin
            if ((c == CH_X || c == "X") && (pr_base == BASE_SIXTEEN || pr_base == BASE_AUTO))
            begin
                pr_base  = BASE_SIXTEEN;
                pr_seen  = 1'b0;
                pr_phase = PH_DIGITS;
                return;
            end
            if ((c == CH_B || c == "B") && (pr_base == BASE_TWO || pr_base == BASE_AUTO))
            begin
                pr_base  = BASE_TWO;
                pr_seen  = 1'b0;
                pr_phase = PH_DIGITS;
                return;
            end
        end
        if (pr_phase != PH_DIGITS && pr_base == BASE_AUTO)
            pr_base = BASE_TEN;
        pr_phase = PH_DIGITS;
        add_digit(c);
    endfunction

    function automatic void compare_result(input result_t want, input result_t got);
        if (got.value !== want.value)
        begin
            $error("value: expected %h, got %h", want.value, got.value);
            fail_count++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.bad_character !== want.bad_character)
        begin
            $error("bad_character: expected %h, got %h", want.bad_character, got.bad_character);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {value, status, bad_character};
                if (due_numbers.size() == 0)
                begin
                    $error("result transfer with nothing outstanding: value %h status %0d",
                           value, status);
                    fail_count++;
                end
                else
                    compare_result(due_numbers.pop_front(), got);
                last_result = got;
                results_seen++;
            end
            if (in_valid && in_ready)
            begin
                consume_char(character);
                chars_accepted++;
            end
        end
    end

    task automatic push_char(input logic [7:0] c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        character <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_text();
        int k;
        for (k = 0; k < text_buf.size(); k++)
            push_char(text_buf[k]);
        push_char(CH_NUL);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_numbers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [4:0] base, input logic [4:0] wdata,
                                input logic sgn);
        cfg_write <= 1'b1;
        cfg_index <= REG_NUMBER_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= REG_TARGET_WIDTH;
        cfg_data  <= wdata;
        @(posedge clk);
        cfg_index <= REG_TARGET_SIGNED;
        cfg_data  <= {4'($urandom_range(15)), sgn};
        @(posedge clk);
        cfg_write <= 1'b0;
        reg_base   = base;
        reg_width  = wdata[1:0];
        reg_signed = sgn;
        settings_written++;
    endtask

    function automatic void add_row(input logic [4:0] base, input logic [1:0] w,
                                    input logic sgn, input string text, input logic typed,
                                    input logic [63:0] val, input logic [2:0] st,
                                    input logic [7:0] bad);
        table_row_t r;
        r.base  = base;
        r.width = w;
        r.sgn   = sgn;
        r.typed = typed;
        r.want  = {val, st, bad};
        rows.push_back(r);
        row_text.push_back(text);
    endfunction

    function automatic void build_random_text();
        logic [7:0]  digs[$];
        logic [4:0]  b;
        logic [4:0]  d;
        logic [63:0] m;
        logic [63:0] lim;
        logic        minus;
        logic        over;
        text_buf.delete();
        minus = 1'b0;
        over  = 1'b0;
        if ($urandom_range(99) < 10)
        begin
            repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(1, 255)));
            return;
        end
        case ($urandom_range(3))
            0:
            begin
                text_buf.push_back(CH_MINUS);
                minus = 1'b1;
            end
            1: text_buf.push_back(CH_PLUS);
            default: ;
        endcase
        b = reg_base;
        if (reg_base == BASE_AUTO)
        begin
            case ($urandom_range(4))
                0, 1:
                begin
                    b = BASE_SIXTEEN;
                    text_buf.push_back(CH_ZERO);
                    text_buf.push_back($urandom_range(1) ? CH_X : "X");
                end
                2:
                begin
                    b = BASE_TWO;
                    text_buf.push_back(CH_ZERO);
                    text_buf.push_back($urandom_range(1) ? CH_B : "B");
                end
                default: b = BASE_TEN;
            endcase
        end
        else if (reg_base == 5'd1 || reg_base > BASE_SIXTEEN)
            b = BASE_TEN;
        else if ((reg_base == BASE_SIXTEEN || reg_base == BASE_TWO) && $urandom_range(1))
        begin
            text_buf.push_back(CH_ZERO);
            text_buf.push_back((reg_base == BASE_TWO) ? CH_B : CH_X);
        end
        if ($urandom_range(11) != 0)
        begin
            lim = ceiling_of(reg_width, reg_signed, minus);
            case ($urandom_range(3))
                0: m = lim - 64'($urandom_range(2));
                1:
                begin
                    m = lim + 64'($urandom_range(1, 2));
                    if (m < lim)
                    begin
                        m    = lim;
                        over = 1'b1;
                    end
                end
                default: m = {$urandom, $urandom} >> $urandom_range(63);
            endcase
            if ($urandom_range(9) == 0)
                text_buf.push_back(CH_ZERO);
            do
            begin
                d = 5'(m % b);
                m = m / b;
                if (d < 5'd10)
                    digs.push_front(CH_ZERO + 8'(d));
                else
                    digs.push_front(($urandom_range(1) ? "A" : "a") + 8'(d) - 8'd10);
            end
            while (m != 64'd0);
            foreach (digs[k])
                text_buf.push_back(digs[k]);
            if (over)
                text_buf.push_back(CH_ZERO);
        end
        if (text_buf.size() != 0 && $urandom_range(5) == 0)
        begin
            text_buf[$urandom_range(text_buf.size() - 1)] =
                $urandom_range(1) ? 8'($urandom_range(1, 255)) : CH_MINUS;
        end
    endfunction

    initial
    begin
        int         i;
        int         k;
        int         p;
        int         phase_end;
        logic [4:0] base_pick;
        string      s;

        add_row(5'd10, 2'd3, 1'b1, "-9223372036854775808", 1'b1, 64'h8000000000000000,
                ST_OK, 8'h00);
        add_row(5'd10, 2'd3, 1'b1, "9223372036854775808", 1'b1, 64'd0, ST_RANGE, 8'h00);
        add_row(5'd10, 2'd3, 1'b0, "18446744073709551615", 1'b1, 64'hffffffffffffffff,
                ST_OK, 8'h00);
        add_row(5'd10, 2'd3, 1'b0, "18446744073709551616", 1'b1, 64'd0, ST_RANGE, 8'h00);
        add_row(5'd10, 2'd3, 1'b0, "-1", 1'b1, 64'd0, ST_RANGE, 8'h00);
        add_row(5'd10, 2'd0, 1'b1, "-128", 1'b1, 64'hffffffffffffff80, ST_OK, 8'h00);
        add_row(5'd10, 2'd0, 1'b1, "+128", 1'b1, 64'd0, ST_RANGE, 8'h00);
        add_row(5'd10, 2'd0, 1'b0, "255", 1'b1, 64'd255, ST_OK, 8'h00);
        add_row(5'd16, 2'd1, 1'b0, "0xFFFF", 1'b1, 64'hffff, ST_OK, 8'h00);
        add_row(5'd16, 2'd1, 1'b1, "-8000", 1'b1, 64'hffffffffffff8000, ST_OK, 8'h00);
        add_row(5'd0, 2'd2, 1'b1, "0x7fffffff", 1'b1, 64'h7fffffff, ST_OK, 8'h00);
        add_row(5'd0, 2'd2, 1'b0, "0B101", 1'b1, 64'd5, ST_OK, 8'h00);
        add_row(5'd0, 2'd2, 1'b1, "0x", 1'b1, 64'd0, ST_NODIGITS, 8'h00);
        add_row(5'd0, 2'd2, 1'b1, "", 1'b1, 64'd0, ST_NODIGITS, 8'h00);
        add_row(5'd1, 2'd2, 1'b1, "", 1'b1, 64'd0, ST_BADBASE, 8'h00);
        add_row(5'd31, 2'd2, 1'b1, "-5", 1'b1, 64'd0, ST_BADBASE, 8'h00);
        add_row(5'd2, 2'd3, 1'b1, "0b12", 1'b1, 64'd0, ST_BADCHAR, "2");
        add_row(5'd10, 2'd3, 1'b1, "+-5", 1'b1, 64'd0, ST_BADCHAR, CH_MINUS);
        add_row(5'd10, 2'd3, 1'b1, "-0", 1'b1, 64'd0, ST_OK, 8'h00);
        add_row(5'd8, 2'd3, 1'b1, "0x1", 1'b1, 64'd0, ST_BADCHAR, CH_X);
        add_row(5'd10, 2'd3, 1'b1, "1$x", 1'b1, 64'd0, ST_BADCHAR, "$");
        s = "12?";
        s.putc(2, 8'hff);
        add_row(5'd10, 2'd3, 1'b1, s, 1'b1, 64'd0, ST_BADCHAR, 8'hff);
        add_row(5'd16, 2'd3, 1'b1, "0b1", 1'b0, 64'd0, ST_OK, 8'h00);
        add_row(5'd0, 2'd3, 1'b1, "0XaF", 1'b0, 64'd0, ST_OK, 8'h00);
        add_row(5'd3, 2'd1, 1'b1, "-210", 1'b0, 64'd0, ST_OK, 8'h00);
        add_row(5'd0, 2'd3, 1'b1, "007", 1'b0, 64'd0, ST_OK, 8'h00);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < rows.size(); i++)
        begin
            if (rows[i].base != reg_base || rows[i].width != reg_width ||
                rows[i].sgn != reg_signed)
                write_config(rows[i].base, {3'b000, rows[i].width}, rows[i].sgn);
            text_buf.delete();
            for (k = 0; k < row_text[i].len(); k++)
                text_buf.push_back(row_text[i][k]);
            send_text();
            wait_idle();
            if (rows[i].typed)
                compare_result(rows[i].want, last_result);
        end

        for (p = 0; p < 3; p++)
        begin
            tx_idle_pct = (p == 0) ? 28 : (p == 1) ? 48 : 0;
            rx_idle_pct = (p == 0) ? 48 : (p == 1) ? 28 : 0;
            phase_end   = chars_accepted + 280;
            while (chars_accepted < phase_end)
            begin
                wait_idle();
                case ($urandom_range(9))
                    0, 6: base_pick = BASE_AUTO;
                    1, 9: base_pick = BASE_TWO;
                    2, 7: base_pick = BASE_SIXTEEN;
                    3: base_pick = BASE_TEN;
                    8: base_pick = $urandom_range(1) ? 5'd1 : 5'($urandom_range(17, 31));
                    default: base_pick = 5'($urandom_range(2, 16));
                endcase
                write_config(base_pick, {3'($urandom_range(7)), 2'($urandom_range(3))},
                             1'($urandom_range(1)));
                repeat ($urandom_range(3, 8))
                begin
                    build_random_text();
                    send_text();
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("parsed %0d results from %0d characters", results_seen, chars_accepted);
        $display("%0d register settings, auto and fixed bases, all target widths and signs",
                 settings_written);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("timeout: parser stopped making progress");
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/isp_pkg.sv
hdl/isp_step.sv
hdl/integer_string_parser_top.sv
bench/integer_string_parser_top_tb.sv
